// ===== hw/rtl/scfb_pkg.sv =====
// Servo command frame builder: shared types, protocol constants and the
// per-position frame byte decoder. No dependencies.
package scfb_pkg;

	localparam logic [7:0] HDR_BYTE       = 8'hFF;
	localparam logic [7:0] BROADCAST_ID   = 8'hFE;
	localparam logic [7:0] INS_WRITE      = 8'h03;
	localparam logic [7:0] INS_READ       = 8'h02;
	localparam logic [7:0] INS_SYNC_WRITE = 8'h83;
	localparam logic [7:0] REG_TORQUE     = 8'd40;
	localparam logic [7:0] REG_GOAL       = 8'd42;
	localparam logic [7:0] REG_FEEDBACK   = 8'd56;
	localparam logic [7:0] FEEDBACK_LEN   = 8'd8;
	localparam logic [7:0] LEN_TORQUE     = 8'd4;
	localparam logic [7:0] LEN_SETPOS     = 8'd9;
	localparam logic [7:0] LEN_SYNC       = 8'd18;
	localparam logic [7:0] LEN_READ       = 8'd4;
	localparam logic [7:0] SYNC_DATA_LEN  = 8'd6;

	localparam int          FRAME_MAX = 22;
	localparam int          IDX_W     = $clog2(FRAME_MAX);

	// command codes
	localparam logic [2:0] OP_TORQUE_ON  = 3'd0;
	localparam logic [2:0] OP_TORQUE_OFF = 3'd1;
	localparam logic [2:0] OP_SET_POS    = 3'd2;
	localparam logic [2:0] OP_SYNC_POS   = 3'd3;
	localparam logic [2:0] OP_READ       = 3'd4;

	// configuration register indexes
	localparam logic CFG_LEFT_ID  = 1'b0;
	localparam logic CFG_RIGHT_ID = 1'b1;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  servo_id;
		logic        side;
		logic [15:0] position;
		logic [15:0] position_right;
		logic [15:0] speed;
	} cmd_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
	} word_t;

	// byte handed from the sequencer to the output register
	typedef struct packed {
		logic  valid;
		word_t word;
	} stage_t;

	function automatic logic op_known(input logic [2:0] op);
		logic ok;
		case (op) inside
			OP_TORQUE_ON, OP_TORQUE_OFF, OP_SET_POS, OP_SYNC_POS, OP_READ: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	// index of the checksum byte
	function automatic logic [IDX_W-1:0] last_idx(input logic [2:0] op);
		logic [IDX_W-1:0] n;
		case (op)
			OP_SET_POS:  n = IDX_W'(12);
			OP_SYNC_POS: n = IDX_W'(21);
			default:     n = IDX_W'(7);
		endcase
		return n;
	endfunction

	// posH posL 00 00 spdH spdL
	function automatic logic [7:0] motion_byte(input logic [15:0] pos,
			input logic [15:0] spd, input logic [2:0] k);
		logic [7:0] b;
		case (k)
			3'd0:    b = pos[15:8];
			3'd1:    b = pos[7:0];
			3'd4:    b = spd[15:8];
			3'd5:    b = spd[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// frame byte at position idx, checksum excluded
	function automatic logic [7:0] frame_byte(input cmd_t c, input logic [IDX_W-1:0] idx,
			input logic [7:0] left_id, input logic [7:0] right_id);
		logic [7:0]       b;
		logic [IDX_W-1:0] k6;
		logic [IDX_W-1:0] k8;
		logic [IDX_W-1:0] k15;
		k6  = idx - IDX_W'(6);
		k8  = idx - IDX_W'(8);
		k15 = idx - IDX_W'(15);
		b   = HDR_BYTE;
		if (idx >= IDX_W'(2)) begin
			case (c.opcode) inside
				OP_TORQUE_ON, OP_TORQUE_OFF: begin
					case (idx)
						IDX_W'(2): b = c.servo_id;
						IDX_W'(3): b = LEN_TORQUE;
						IDX_W'(4): b = INS_WRITE;
						IDX_W'(5): b = REG_TORQUE;
						default:   b = (c.opcode == OP_TORQUE_ON) ? 8'd1 : 8'd0;
					endcase
				end
				OP_SET_POS: begin
					case (idx)
						IDX_W'(2): b = c.servo_id;
						IDX_W'(3): b = LEN_SETPOS;
						IDX_W'(4): b = INS_WRITE;
						IDX_W'(5): b = REG_GOAL;
						default:   b = motion_byte(c.position, c.speed, k6[2:0]);
					endcase
				end
				OP_SYNC_POS: begin
					if (idx == IDX_W'(2))       b = BROADCAST_ID;
					else if (idx == IDX_W'(3))  b = LEN_SYNC;
					else if (idx == IDX_W'(4))  b = INS_SYNC_WRITE;
					else if (idx == IDX_W'(5))  b = REG_GOAL;
					else if (idx == IDX_W'(6))  b = SYNC_DATA_LEN;
					else if (idx == IDX_W'(7))  b = left_id;
					else if (idx < IDX_W'(14))  b = motion_byte(c.position, c.speed, k8[2:0]);
					else if (idx == IDX_W'(14)) b = right_id;
					else b = motion_byte(c.position_right, c.speed, k15[2:0]);
				end
				default: begin
					case (idx)
						IDX_W'(2): b = c.side ? right_id : left_id;
						IDX_W'(3): b = LEN_READ;
						IDX_W'(4): b = INS_READ;
						IDX_W'(5): b = REG_FEEDBACK;
						default:   b = FEEDBACK_LEN;
					endcase
				end
			endcase
		end
		return b;
	endfunction

endpackage

// ===== hw/rtl/scfb_seq.sv =====
// Frame sequencer: command register, byte index and running checksum.
// Depends on scfb_pkg.
module scfb_seq import scfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	input  logic [7:0] left_id,
	input  logic [7:0] right_id,
	input  logic       stage_ready,
	output stage_t     stage
);

	cmd_t             cmd_s1;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       sum_q;
	logic [7:0]       data_byte;
	logic             at_last;
	logic             adv;
	logic             take;

	assign data_byte = frame_byte(cmd_s1, idx_q, left_id, right_id);
	assign at_last   = (idx_q == last_idx(cmd_s1.opcode));
	assign adv       = busy_q && stage_ready;
	assign cmd_ready = !busy_q || (adv && at_last);
	assign take      = cmd_valid && cmd_ready;

	assign stage.valid        = busy_q;
	assign stage.word.tx_byte = at_last ? ~sum_q : data_byte;
	assign stage.word.last    = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			sum_q  <= '0;
		end else if (take) begin
			busy_q <= op_known(cmd.opcode);
			idx_q  <= '0;
			sum_q  <= '0;
		end else if (adv) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
				// header bytes stay out of the checksum
				if (idx_q >= IDX_W'(2)) begin
					sum_q <= sum_q + data_byte;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
		end
	end

endmodule

// ===== hw/rtl/scfb_out.sv =====
// Output register between the sequencer and the byte receiver.
// Depends on scfb_pkg.
module scfb_out import scfb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  stage_t stage,
	output logic   stage_ready,
	output logic   tx_valid,
	input  logic   tx_ready,
	output word_t  tx
);

	logic  valid_q;
	word_t word_q;

	assign stage_ready = !valid_q || tx_ready;
	assign tx_valid    = valid_q;
	assign tx          = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (stage_ready) begin
			valid_q <= stage.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_ready && stage.valid) begin
			word_q <= stage.word;
		end
	end

endmodule

// ===== hw/rtl/servo_command_frame_builder_top.sv =====
// Servo command frame builder, top level: ID registers, sequencer, output register.
// Depends on scfb_pkg, scfb_seq and scfb_out.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one servo command per word.
//   tx channel (tx_valid/tx_ready/tx) gives the frame one byte per word;
//   tx.last marks the checksum byte that closes a frame.
//   cfg_we/cfg_index/cfg_data write left_id (index 0) or right_id (index 1);
//   write them only while no frame is in flight.
// Frames are 8 (torque, read), 13 (set position) or 22 (sync) bytes; the first
//   header byte shows on tx once the sequencer and the output register hold it.
// Throughput: one byte per cycle while tx_ready is high, set by the single byte
//   sequencer; the next command is taken in the cycle the checksum byte moves
//   into the output register, so frames follow back to back with no gap.
// Undefined command codes are taken and produce no bytes.
// Reset clears the sequencer and output valid, and sets left_id to 1 and
//   right_id to 2.
// Stall: when tx_ready is low the output register holds its byte and the
//   sequencer holds position; cmd_ready stays low until the frame is done.
module servo_command_frame_builder_top import scfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       tx_valid,
	input  logic       tx_ready,
	output word_t      tx,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] left_id_q;
	logic [7:0] right_id_q;
	stage_t     stage;
	logic       stage_ready;

	// servo ID registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_id_q  <= 8'd1;
			right_id_q <= 8'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEFT_ID:  left_id_q  <= cfg_data;
				CFG_RIGHT_ID: right_id_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// walks the frame byte by byte, accumulating the checksum
	scfb_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.left_id     (left_id_q),
		.right_id    (right_id_q),
		.stage_ready (stage_ready),
		.stage       (stage)
	);

	// output register decouples the receiver's stalls at full rate
	scfb_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.stage       (stage),
		.stage_ready (stage_ready),
		.tx_valid    (tx_valid),
		.tx_ready    (tx_ready),
		.tx          (tx)
	);

endmodule

// ===== hw/rtl/scfb_checker.sv =====
// Port-level checker for the servo command frame builder, bound to the top.
// Depends on scfb_pkg and servo_command_frame_builder_top.
module scfb_checker import scfb_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  tx_valid,
	input logic  tx_ready,
	input word_t tx
);

	logic [IDX_W-1:0] pos_q;
	logic             acc;

	assign acc = tx_valid && tx_ready;

	// byte position within the frame on the tx side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (acc) begin
			pos_q <= tx.last ? '0 : pos_q + IDX_W'(1);
		end
	end

	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx))
		else $error("tx word changed while stalled");

	a_header: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pos_q < IDX_W'(2) |-> tx.tx_byte == HDR_BYTE && !tx.last)
		else $error("frame does not open with two header bytes");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		acc && tx.last |-> pos_q == IDX_W'(7) || pos_q == IDX_W'(12) || pos_q == IDX_W'(21))
		else $error("frame ends at an illegal length");

	a_max_len: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pos_q == IDX_W'(21) |-> tx.last)
		else $error("frame longer than the longest frame");

endmodule

bind servo_command_frame_builder_top scfb_checker u_scfb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.tx_valid (tx_valid),
	.tx_ready (tx_ready),
	.tx       (tx)
);

// ===== tb/servo_command_frame_builder_checker.sv =====
// Frame checker for the servo command frame builder: watches the cmd, tx and cfg ports,
// predicts every frame byte and compares it with what leaves the block.
// Depends on scfb_pkg.
module servo_command_frame_builder_checker
	import scfb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  logic       cmd_ready,
	input  cmd_t       cmd,
	input  logic       tx_valid,
	input  logic       tx_ready,
	input  word_t      tx,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output int         errors,
	output int         bytes_due
);
	timeunit 1ns;
	timeprecision 1ps;

	// longest body: sync frame, ID through the last payload byte
	localparam int BODY_MAX = 19;
	localparam int MAX_SHOWN = 40;

	word_t      frame_due[$];
	word_t      oldest;
	logic [7:0] left_id_q;
	logic [7:0] right_id_q;

	task automatic report_mismatch(input string msg);
		errors = errors + 1;
		if (errors <= MAX_SHOWN) $display("[%0t] frame check: %s", $time, msg);
	endtask

	// queue the bytes of the frame that one command produces
	function automatic void predict_frame(input cmd_t c);
		logic [8*BODY_MAX-1:0] body;
		int                    nbody;
		logic [7:0]            b;
		logic [7:0]            sum;
		word_t                 w;
		body  = '0;
		nbody = 0;
		sum   = '0;
		case (c.opcode)
			OP_TORQUE_ON, OP_TORQUE_OFF: begin
				body[8*BODY_MAX-1 -: 40] = {c.servo_id, LEN_TORQUE, INS_WRITE, REG_TORQUE,
					(c.opcode == OP_TORQUE_ON) ? 8'd1 : 8'd0};
				nbody = 5;
			end
			OP_SET_POS: begin
				body[8*BODY_MAX-1 -: 80] = {c.servo_id, LEN_SETPOS, INS_WRITE, REG_GOAL,
					c.position, 16'h0000, c.speed};
				nbody = 10;
			end
			OP_SYNC_POS: begin
				body = {BROADCAST_ID, LEN_SYNC, INS_SYNC_WRITE, REG_GOAL, SYNC_DATA_LEN,
					left_id_q, c.position, 16'h0000, c.speed,
					right_id_q, c.position_right, 16'h0000, c.speed};
				nbody = 19;
			end
			OP_READ: begin
				body[8*BODY_MAX-1 -: 40] = {c.side ? right_id_q : left_id_q, LEN_READ,
					INS_READ, REG_FEEDBACK, FEEDBACK_LEN};
				nbody = 5;
			end
			default: nbody = 0;
		endcase
		if (nbody == 0) return;
		w.last    = 1'b0;
		w.tx_byte = HDR_BYTE;
		frame_due.push_back(w);
		frame_due.push_back(w);
		for (int i = 0; i < nbody; i++) begin
			b         = body[8*BODY_MAX-1-8*i -: 8];
			sum       = sum + b;
			w.tx_byte = b;
			frame_due.push_back(w);
		end
		w.tx_byte = ~sum;
		w.last    = 1'b1;
		frame_due.push_back(w);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_due.delete();
			left_id_q  <= 8'd1;
			right_id_q <= 8'd2;
			errors = 0;
			bytes_due  <= 0;
		end else begin
			// a byte leaving now can never belong to a command taken at this edge
			if (tx_valid && tx_ready) begin
				if (frame_due.size() == 0) begin
					report_mismatch($sformatf("unexpected word %02h last=%0b",
						tx.tx_byte, tx.last));
				end else begin
					oldest = frame_due.pop_front();
					if (tx.tx_byte !== oldest.tx_byte)
						report_mismatch($sformatf("tx_byte %02h, want %02h",
							tx.tx_byte, oldest.tx_byte));
					if (tx.last !== oldest.last)
						report_mismatch($sformatf("last %0b on byte %02h, want %0b",
							tx.last, tx.tx_byte, oldest.last));
				end
			end
			if (cmd_valid && cmd_ready) predict_frame(cmd);
			if (cfg_we) begin
				case (cfg_index)
					CFG_LEFT_ID:  left_id_q  <= cfg_data;
					CFG_RIGHT_ID: right_id_q <= cfg_data;
					default:      ;
				endcase
			end
			bytes_due <= frame_due.size();
		end
	end

endmodule

// ===== tb/servo_command_frame_builder_top_test.sv =====
// Testbench top for the servo command frame builder: clock, reset, command stimulus,
// tx back-pressure and the final verdict. Depends on scfb_pkg, the block's top level
// and servo_command_frame_builder_checker.
module servo_command_frame_builder_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import scfb_pkg::*;

	// command codes the block must swallow without a frame
	localparam logic [2:0] OP_RSVD_5 = 3'd5;
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;

	localparam int RANDOM_PER_PHASE = 53;  // frame-producing commands per phase
	localparam int N_PHASES         = 5;
	localparam int LONG_HOLD        = 400; // cycles of tx_ready low in the pressure phase
	localparam int SETTLE           = 4;   // margin after the last predicted byte has left
	localparam int TAIL             = 40;  // longest frame plus margin

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cmd_valid = 1'b0;
	cmd_t       cmd       = '0;
	logic       tx_ready  = 1'b0;
	logic       cfg_we    = 1'b0;
	logic       cfg_index = 1'b0;
	logic [7:0] cfg_data  = 8'd0;
	logic       cmd_ready;
	logic       tx_valid;
	word_t      tx;
	int         errors;
	int         bytes_due;

	// pacing knobs; sender_idle is only touched by the stimulus process
	int   sender_idle  = 0;
	int   rx_stall_pct = 0;
	// long hold-off: the stimulus flips the request, the receiver counts it out
	logic hold_rx_req  = 1'b0;
	logic hold_rx_seen = 1'b0;
	int   hold_left    = 0;

	int   n_sent     = 0;
	int   n_directed = 0;

	always #10 clk = ~clk;

	servo_command_frame_builder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.tx_valid  (tx_valid),
		.tx_ready  (tx_ready),
		.tx        (tx),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	servo_command_frame_builder_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.tx_valid  (tx_valid),
		.tx_ready  (tx_ready),
		.tx        (tx),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.bytes_due (bytes_due)
	);

	// Receiver side of tx. A pending hold request overrides the random stalls until
	// hold_left has counted out LONG_HOLD, so the output register and the sequencer both fill.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			tx_ready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_rx_req != hold_rx_seen) begin
			hold_rx_seen <= hold_rx_req;
			hold_left    <= LONG_HOLD - 1;
			tx_ready     <= 1'b0;
		end else begin
			tx_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	function automatic cmd_t make_cmd(input logic [2:0] op, input logic [7:0] id,
			input logic sd, input logic [15:0] pos, input logic [15:0] pos_r,
			input logic [15:0] spd);
		cmd_t c;
		c.opcode         = op;
		c.servo_id       = id;
		c.side           = sd;
		c.position       = pos;
		c.position_right = pos_r;
		c.speed          = spd;
		return c;
	endfunction

	// mostly defined codes and in-range IDs; every field bit still toggles
	function automatic cmd_t rand_cmd();
		cmd_t c;
		if ($urandom_range(0, 9) == 0) c.opcode = 3'($urandom_range(5, 7));
		else                           c.opcode = 3'($urandom_range(0, 4));
		if ($urandom_range(0, 15) == 0) c.servo_id = 8'($urandom_range(254, 255));
		else                            c.servo_id = 8'($urandom_range(0, 253));
		c.side           = 1'($urandom);
		c.position       = 16'($urandom);
		c.position_right = 16'($urandom);
		c.speed          = 16'($urandom);
		// pin the motion fields to their extremes now and then
		case ($urandom_range(0, 7))
			0: c.position = 16'h0000;
			1: c.position = 16'hFFFF;
			2: c.speed    = 16'hFFFF;
			3: c.position_right = 16'h0000;
			default: ;
		endcase
		return c;
	endfunction

	// Offer one command word and return at the edge that takes it. Valid is only
	// dropped when a sender gap is drawn, so back-to-back words keep it high.
	task automatic send_cmd(input cmd_t c);
		while ($urandom_range(0, 99) < sender_idle) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		n_sent++;
	endtask

	// stop offering and wait until every predicted byte has left the block
	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (bytes_due != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write both ID registers; only called with the block drained
	task automatic set_ids(input logic [7:0] left, input logic [7:0] right);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LEFT_ID;
		cfg_data  <= left;
		@(posedge clk);
		cfg_index <= CFG_RIGHT_ID;
		cfg_data  <= right;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		cmd_t c;
		int   valid_sent;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset IDs (left 1, right 2), no idling.
		// Torque frames with edge IDs, including the two out-of-range ones.
		send_cmd(make_cmd(OP_TORQUE_ON,  8'd0,   1'b0, 16'h0000, 16'h0000, 16'h0000));
		send_cmd(make_cmd(OP_TORQUE_ON,  8'd253, 1'b0, 16'h0000, 16'h0000, 16'h0000));
		send_cmd(make_cmd(OP_TORQUE_OFF, 8'd254, 1'b0, 16'h0000, 16'h0000, 16'h0000));
		send_cmd(make_cmd(OP_TORQUE_OFF, 8'd255, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		// unused fields all ones must not leak into a torque frame
		send_cmd(make_cmd(OP_TORQUE_ON,  8'd7,   1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		// set position: all-zero and all-ones motion fields, then mixed bytes
		send_cmd(make_cmd(OP_SET_POS,    8'd1,   1'b0, 16'h0000, 16'h0000, 16'h0000));
		send_cmd(make_cmd(OP_SET_POS,    8'd255, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_cmd(make_cmd(OP_SET_POS,    8'd0,   1'b0, 16'h1234, 16'h5A5A, 16'h8001));
		// sync: broadcast ID regardless of servo_id, both positions at opposite extremes
		send_cmd(make_cmd(OP_SYNC_POS,   8'd99,  1'b0, 16'h0000, 16'hFFFF, 16'h0000));
		send_cmd(make_cmd(OP_SYNC_POS,   8'd255, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF));
		// read request on each side, servo_id ignored
		send_cmd(make_cmd(OP_READ,       8'd255, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_cmd(make_cmd(OP_READ,       8'd0,   1'b1, 16'h0000, 16'h0000, 16'h0000));
		// undefined codes produce nothing, also right before and after real frames
		send_cmd(make_cmd(OP_RSVD_5,     8'd3,   1'b1, 16'hAAAA, 16'h5555, 16'hFFFF));
		send_cmd(make_cmd(OP_TORQUE_OFF, 8'd128, 1'b0, 16'h0000, 16'h0000, 16'h0000));
		send_cmd(make_cmd(OP_RSVD_6,     8'd255, 1'b0, 16'hFFFF, 16'h0000, 16'h0000));
		send_cmd(make_cmd(OP_RSVD_7,     8'd0,   1'b1, 16'h0000, 16'hFFFF, 16'h1234));
		send_cmd(make_cmd(OP_READ,       8'd17,  1'b1, 16'h4321, 16'h8765, 16'hCAFE));
		n_directed = n_sent;
		drain();

		// Random phases, each with its own IDs and pacing.
		for (int phase = 0; phase < N_PHASES; phase++) begin
			case (phase)
				0: begin
					set_ids(8'd0, 8'd253);
					sender_idle  = 0;
					rx_stall_pct <= 0;
				end
				1: begin
					set_ids(8'd253, 8'd0);
					sender_idle  = 60;
					rx_stall_pct <= 0;
				end
				2: begin
					set_ids(8'($urandom_range(0, 253)), 8'($urandom_range(0, 253)));
					sender_idle  = 0;
					rx_stall_pct <= 60;
				end
				3: begin
					set_ids(8'($urandom_range(0, 253)), 8'($urandom_range(0, 253)));
					sender_idle  = 27;
					rx_stall_pct <= 27;
				end
				default: begin
					// pressure: tx held off while commands keep coming, so cmd_ready drops
					set_ids(8'd253, 8'd253);
					sender_idle  = 0;
					rx_stall_pct <= 0;
					hold_rx_req  <= ~hold_rx_req;
				end
			endcase
			valid_sent = 0;
			while (valid_sent < RANDOM_PER_PHASE) begin
				c = rand_cmd();
				send_cmd(c);
				if (c.opcode <= OP_READ) valid_sent++;
			end
			// sender pause: nothing new until every expected byte is out
			drain();
		end

		repeat (TAIL) @(posedge clk);
		$display("Sent %0d command words (%0d directed) across %0d ID settings,",
			n_sent, n_directed, N_PHASES + 1);
		$display("four pacing modes and a %0d-cycle tx hold-off.", LONG_HOLD);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
